FILE: rtl/core/kpb_pkg.sv
// kpb_pkg: shared constants, request codes and controller/datapath interface types
// for the k-mer presence bitmap mutation scan core. No dependencies.
`timescale 1ns / 1ps
package kpb_pkg;

   localparam int MAX_K      = 12;
   localparam int HIST_BITS  = 40;
   localparam int HIST_BINS  = MAX_K + 1;
   localparam int WIN_BASES  = 2 * MAX_K - 1;
   localparam int WIN_W      = 2 * WIN_BASES;
   localparam int KEY_W      = 2 * MAX_K;
   localparam int ROW_W      = 64;
   localparam int BIT_W      = 6;
   localparam int ROW_AW     = KEY_W - BIT_W;
   localparam int K_W        = 4;
   localparam int FILL_W     = 5;
   localparam int SKIP_W     = 16;
   localparam int DIST_W     = KEY_W + 1;
   localparam int CSR_DATA_W = 16;
   localparam int BIN_W      = 4;
   localparam int CNT_W      = 4;

   localparam logic [1:0] BASE_MASK = 2'h3;

   typedef enum logic [1:0] {
      REQ_BUILD = 2'd0,
      REQ_SCAN  = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic {
      CSR_KMER_SIZE     = 1'b0,
      CSR_SKIP_DISTANCE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KEY_FWD  = 2'd0,
      KEY_REV  = 2'd1,
      KEY_SCAN = 2'd2
   } key_sel_type;

   // controller -> datapath
   typedef struct packed {
      logic        clear;    // write one zero row of the bitmap
      logic        take;     // latch a new word and update the window
      logic        mem_rd;   // read the bitmap row of the selected key
      key_sel_type key_sel;
      logic        mem_set;  // set the key bit in the row just read
      logic        check;    // test one mutated k-mer
      logic        bump;     // bump the histogram bin
      logic        emit;     // drive the result word
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic         clear_last;
      req_kind_type req_kind;
      logic         build_ok;
      logic         eval;
      logic         last_kmer;
   } status_type;

endpackage

FILE: rtl/core/kpb_ctrl.sv
// kpb_ctrl: sequencer for the k-mer presence bitmap core.
// Depends on kpb_pkg for command/status types.
`timescale 1ns / 1ps
module kpb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  kpb_pkg::status_type status,
   output kpb_pkg::cmd_type   cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DISP, ST_B_RD1, ST_B_WR1, ST_B_RD2, ST_B_WR2,
      ST_S_RD, ST_S_CHK, ST_S_HIST, ST_FIN
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (status.clear_last) state_in = ST_IDLE;
         ST_IDLE:   if (start) state_in = ST_DISP;
         ST_DISP: begin
            priority if (status.req_kind == kpb_pkg::REQ_BUILD && status.build_ok)
               state_in = ST_B_RD1;
            else if (status.req_kind == kpb_pkg::REQ_SCAN && status.eval)
               state_in = ST_S_RD;
            else
               state_in = ST_FIN;
         end
         ST_B_RD1:  state_in = ST_B_WR1;
         ST_B_WR1:  state_in = ST_B_RD2;
         ST_B_RD2:  state_in = ST_B_WR2;
         ST_B_WR2:  state_in = ST_FIN;
         ST_S_RD:   state_in = ST_S_CHK;
         ST_S_CHK:  state_in = status.last_kmer ? ST_S_HIST : ST_S_RD;
         ST_S_HIST: state_in = ST_FIN;
         ST_FIN:    state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // commands decoded from state
   always_comb begin
      cmd = '0;
      cmd.key_sel = kpb_pkg::KEY_FWD;
      unique case (state_ff)
         ST_CLEAR:  cmd.clear = 1'b1;
         ST_IDLE:   cmd.take = start;
         ST_B_RD1:  cmd.mem_rd = 1'b1;
         ST_B_WR1:  cmd.mem_set = 1'b1;
         ST_B_RD2: begin
            cmd.mem_rd  = 1'b1;
            cmd.key_sel = kpb_pkg::KEY_REV;
         end
         ST_B_WR2: begin
            cmd.mem_set = 1'b1;
            cmd.key_sel = kpb_pkg::KEY_REV;
         end
         ST_S_RD: begin
            cmd.mem_rd  = 1'b1;
            cmd.key_sel = kpb_pkg::KEY_SCAN;
         end
         ST_S_CHK:  cmd.check = 1'b1;
         ST_S_HIST: cmd.bump = 1'b1;
         ST_FIN:    cmd.emit = 1'b1;
         default:   cmd = cmd;
      endcase
   end

endmodule

FILE: rtl/core/kpb_datapath.sv
// kpb_datapath: base window, presence bitmap memory, histogram and result word.
// Depends on kpb_pkg; driven by kpb_ctrl commands.
`timescale 1ns / 1ps
module kpb_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  kpb_pkg::cmd_type                  cmd,
   output kpb_pkg::status_type               status,
   input  logic                              csr_write_enable,
   input  logic                              csr_index,
   input  logic [kpb_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic [1:0]                        req_type,
   input  logic [1:0]                        req_base_code,
   input  logic                              req_sequence_start,
   input  logic [kpb_pkg::BIN_W-1:0]         req_bin_index,
   output logic                              rsp_valid,
   output logic                              rsp_fragment_done,
   output logic [kpb_pkg::CNT_W-1:0]         rsp_absent_count,
   output logic [kpb_pkg::HIST_BITS-1:0]     rsp_read_value
);

   localparam int WW = kpb_pkg::WIN_W;
   localparam int KW = kpb_pkg::KEY_W;

   // configuration
   logic [kpb_pkg::K_W-1:0]    kmer_size_ff;
   logic [kpb_pkg::SKIP_W-1:0] skip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_size_ff <= kpb_pkg::K_W'(12);
         skip_ff      <= kpb_pkg::SKIP_W'(100);
      end else if (csr_write_enable) begin
         unique case (kpb_pkg::csr_index_type'(csr_index))
            kpb_pkg::CSR_KMER_SIZE:     kmer_size_ff <= csr_write_data[kpb_pkg::K_W-1:0];
            kpb_pkg::CSR_SKIP_DISTANCE: skip_ff      <= csr_write_data;
            default:                    skip_ff      <= skip_ff;
         endcase
      end
   end

   // sequence state
   logic [WW-1:0]                 win_ff, win_in;
   logic [kpb_pkg::FILL_W-1:0]    fill_ff, fill_in;
   logic [kpb_pkg::SKIP_W-1:0]    phase_ff, phase_in;
   logic [kpb_pkg::DIST_W-1:0]    distinct_ff;

   // per-word registers
   kpb_pkg::req_kind_type         kind_ff, kind_in;
   logic [kpb_pkg::BIN_W-1:0]     bin_ff;
   logic [kpb_pkg::K_W-1:0]       k_ff, k_in;
   logic                          ok_ff, ok_in;
   logic                          eval_ff, eval_in;
   logic [KW-1:0]                 fwd_ff, fwd_in;
   logic [KW-1:0]                 rev_ff, rev_in;
   logic [WW-1:0]                 frag_ff, frag_in;
   logic [kpb_pkg::K_W-1:0]       j_ff;
   logic [kpb_pkg::CNT_W-1:0]     n_ff;

   // window update for an accepted word
   always_comb begin
      logic [WW-1:0]              w0;
      logic [kpb_pkg::FILL_W-1:0] f0;
      logic [kpb_pkg::SKIP_W-1:0] p0;
      logic [kpb_pkg::FILL_W-1:0] flen;
      logic [kpb_pkg::SKIP_W-1:0] skip;
      logic [kpb_pkg::SKIP_W:0]   p1;
      logic [WW:0]                fmask;
      logic [KW:0]                kmask;
      logic [KW-1:0]              comp;
      logic [KW-1:0]              rrev;
      logic [5:0]                 sh;
      logic [1:0]                 c;
      logic                       is_base;

      kind_in  = kpb_pkg::req_kind_type'(req_type);
      is_base  = (req_type == kpb_pkg::REQ_BUILD) || (req_type == kpb_pkg::REQ_SCAN);
      k_in     = (kmer_size_ff == '0) ? kpb_pkg::K_W'(1) :
                 (kmer_size_ff > kpb_pkg::K_W'(kpb_pkg::MAX_K)) ?
                 kpb_pkg::K_W'(kpb_pkg::MAX_K) : kmer_size_ff;
      flen     = kpb_pkg::FILL_W'({k_in, 1'b0}) - kpb_pkg::FILL_W'(1);
      skip     = (skip_ff == '0) ? kpb_pkg::SKIP_W'(1) : skip_ff;

      w0 = (is_base && req_sequence_start) ? '0 : win_ff;
      f0 = (is_base && req_sequence_start) ? '0 : fill_ff;
      p0 = (is_base && req_sequence_start) ? '0 : phase_ff;

      win_in  = is_base ? {w0[WW-3:0], req_base_code} : win_ff;
      fill_in = !is_base ? fill_ff :
                (f0 < kpb_pkg::FILL_W'(kpb_pkg::WIN_BASES)) ? f0 + kpb_pkg::FILL_W'(1) : f0;

      // forward k-mer and its reverse complement
      kmask  = ({{KW{1'b0}}, 1'b1} << {k_in, 1'b0}) - 1'b1;
      fwd_in = win_in[KW-1:0] & kmask[KW-1:0];
      comp   = ~fwd_in;
      for (int i = 0; i < kpb_pkg::MAX_K; i++) begin
         rrev[2*i +: 2] = comp[2*(kpb_pkg::MAX_K-1-i) +: 2];
      end
      rev_in = rrev >> {kpb_pkg::K_W'(kpb_pkg::MAX_K) - k_in, 1'b0};
      ok_in  = ({1'b0, fill_in} >= {2'b00, k_in});

      // skip phase and evaluated fragment
      phase_in = p0;
      eval_in  = 1'b0;
      p1       = {1'b0, p0} + 1'b1;
      if (req_type == kpb_pkg::REQ_SCAN && fill_in >= flen) begin
         if (f0 < flen) begin
            phase_in = '0;
         end else begin
            phase_in = (p1 >= {1'b0, skip}) ? '0 : p1[kpb_pkg::SKIP_W-1:0];
         end
         eval_in = (phase_in == '0);
      end else if (!is_base) begin
         phase_in = phase_ff;
      end

      fmask   = ({{WW{1'b0}}, 1'b1} << {flen, 1'b0}) - 1'b1;
      sh      = {1'b0, k_in - kpb_pkg::K_W'(1), 1'b0};
      c       = win_in[sh +: 2];
      frag_in = (win_in & fmask[WW-1:0] & ~({{(WW-2){1'b0}}, kpb_pkg::BASE_MASK} << sh))
                | ({{(WW-2){1'b0}}, c + 2'd1} << sh);
   end

   // current scan k-mer
   logic [KW-1:0] scan_key;
   always_comb begin
      logic [KW:0]  km;
      logic [WW-1:0] sf;
      logic [kpb_pkg::K_W-1:0] d;
      d        = k_ff - kpb_pkg::K_W'(1) - j_ff;
      sf       = frag_ff >> {d, 1'b0};
      km       = ({{KW{1'b0}}, 1'b1} << {k_ff, 1'b0}) - 1'b1;
      scan_key = sf[KW-1:0] & km[KW-1:0];
   end

   // bitmap memory: one write and one registered read per cycle
   logic [kpb_pkg::ROW_W-1:0]  bitmap [2**kpb_pkg::ROW_AW];
   logic [KW-1:0]              key_sel;
   logic [KW-1:0]              key_ff;
   logic [kpb_pkg::ROW_W-1:0]  rd_row_ff;
   logic [kpb_pkg::ROW_AW-1:0] clr_addr_ff;
   logic                       key_hit;

   always_comb begin
      unique case (cmd.key_sel)
         kpb_pkg::KEY_FWD:  key_sel = fwd_ff;
         kpb_pkg::KEY_REV:  key_sel = rev_ff;
         kpb_pkg::KEY_SCAN: key_sel = scan_key;
         default:           key_sel = fwd_ff;
      endcase
   end

   assign key_hit = rd_row_ff[key_ff[kpb_pkg::BIT_W-1:0]];

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         bitmap[clr_addr_ff] <= '0;
      end else if (cmd.mem_set) begin
         bitmap[key_ff[KW-1:kpb_pkg::BIT_W]] <= rd_row_ff |
            (kpb_pkg::ROW_W'(1) << key_ff[kpb_pkg::BIT_W-1:0]);
      end
      if (cmd.mem_rd) begin
         rd_row_ff <= bitmap[key_sel[KW-1:kpb_pkg::BIT_W]];
         key_ff    <= key_sel;
      end
   end

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // histogram, one read port shared by bump and read
   logic [kpb_pkg::HIST_BITS-1:0] hist_ff [kpb_pkg::HIST_BINS];
   logic [kpb_pkg::BIN_W-1:0]     hist_addr;
   logic [kpb_pkg::HIST_BITS-1:0] hist_rd;

   assign hist_addr = cmd.bump ? n_ff : bin_ff;
   assign hist_rd   = (hist_addr <= kpb_pkg::BIN_W'(kpb_pkg::MAX_K)) ?
                      hist_ff[hist_addr] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < kpb_pkg::HIST_BINS; i++) hist_ff[i] <= '0;
      end else if (cmd.bump && hist_rd != '1) begin
         hist_ff[n_ff] <= hist_rd + 1'b1;
      end
   end

   // sequence and per-word registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff      <= '0;
         fill_ff     <= '0;
         phase_ff    <= '0;
         distinct_ff <= '0;
         kind_ff     <= kpb_pkg::REQ_NONE;
         ok_ff       <= 1'b0;
         eval_ff     <= 1'b0;
         j_ff        <= '0;
         n_ff        <= '0;
      end else begin
         if (cmd.take) begin
            win_ff   <= win_in;
            fill_ff  <= fill_in;
            phase_ff <= phase_in;
            kind_ff  <= kind_in;
            ok_ff    <= ok_in;
            eval_ff  <= eval_in;
            j_ff     <= '0;
            n_ff     <= '0;
         end
         if (cmd.mem_set && !key_hit) distinct_ff <= distinct_ff + 1'b1;
         if (cmd.check) begin
            j_ff <= j_ff + 1'b1;
            if (!key_hit) n_ff <= n_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         bin_ff  <= req_bin_index;
         k_ff    <= k_in;
         fwd_ff  <= fwd_in;
         rev_ff  <= rev_in;
         frag_ff <= frag_in;
      end
   end

   assign status.clear_last = (clr_addr_ff == '1);
   assign status.req_kind   = kind_ff;
   assign status.build_ok   = ok_ff;
   assign status.eval       = eval_ff;
   assign status.last_kmer  = (j_ff == k_ff - kpb_pkg::K_W'(1));

   // result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         unique case (kind_ff)
            kpb_pkg::REQ_BUILD: begin
               rsp_fragment_done <= 1'b0;
               rsp_absent_count  <= '0;
               rsp_read_value    <= kpb_pkg::HIST_BITS'(distinct_ff);
            end
            kpb_pkg::REQ_SCAN: begin
               rsp_fragment_done <= eval_ff;
               rsp_absent_count  <= eval_ff ? n_ff : '0;
               rsp_read_value    <= '0;
            end
            kpb_pkg::REQ_READ: begin
               rsp_fragment_done <= 1'b0;
               rsp_absent_count  <= '0;
               rsp_read_value    <= hist_rd;
            end
            kpb_pkg::REQ_NONE: begin
               rsp_fragment_done <= 1'b0;
               rsp_absent_count  <= '0;
               rsp_read_value    <= '0;
            end
         endcase
      end
   end

endmodule

FILE: rtl/core/kmer_presence_bitmap_mutation_scan_core.sv
// kmer_presence_bitmap_mutation_scan_core: top level of the k-mer presence bitmap core.
// Depends on kpb_pkg, kpb_ctrl and kpb_datapath.
`timescale 1ns / 1ps
// Usage:
//  - Request channel: a word (req_type, req_base_code, req_sequence_start,
//    req_bin_index) is taken at a clock edge with start high and busy low.
//  - Result channel: one word per request, shown on the rsp_ ports for one
//    cycle with rsp_valid high. The receiver cannot stall it.
//  - csr_write_enable/csr_index/csr_write_data write kmer_size (0) and
//    skip_distance (1); write only while idle.
//  - From accept to rsp_valid: a build with a full k-mer reads and sets
//    the bitmap bit of the forward k-mer, then of its reverse complement;
//    an evaluated scan does one bitmap read and one check per mutated
//    k-mer, K of them; other requests go straight to the result. A new
//    word may be accepted in the cycle its predecessor's result shows.
//  - Reset: the bitmap is cleared by a sweep of 262144 rows, one 64-bit
//    row per cycle, with busy high; configuration writes are taken meanwhile.
//    Histogram, window and counters clear at once.
module kmer_presence_bitmap_mutation_scan_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_type,
   input  logic [1:0]                        req_base_code,
   input  logic                              req_sequence_start,
   input  logic [kpb_pkg::BIN_W-1:0]         req_bin_index,
   output logic                              rsp_valid,
   output logic                              rsp_fragment_done,
   output logic [kpb_pkg::CNT_W-1:0]         rsp_absent_count,
   output logic [kpb_pkg::HIST_BITS-1:0]     rsp_read_value,
   input  logic                              csr_write_enable,
   input  logic                              csr_index,
   input  logic [kpb_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   kpb_pkg::cmd_type    cmd;
   kpb_pkg::status_type status;

   kpb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   kpb_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_type           (req_type),
      .req_base_code      (req_base_code),
      .req_sequence_start (req_sequence_start),
      .req_bin_index      (req_bin_index),
      .rsp_valid          (rsp_valid),
      .rsp_fragment_done  (rsp_fragment_done),
      .rsp_absent_count   (rsp_absent_count),
      .rsp_read_value     (rsp_read_value)
   );

endmodule
